>>> src/arma_pkg.sv
// shared types and constants for the address region map allocator
package arma_pkg;

	localparam int MAX_REGIONS = 32;
	localparam int PAGE_BITS   = 12;
	localparam int ADDR_BITS   = 48;
	localparam int LEN_BITS    = 49;

	localparam int PW = ADDR_BITS - PAGE_BITS;    // page number
	localparam int EW = PW + 1;                   // end page, may equal 2^PW
	localparam int NW = LEN_BITS - PAGE_BITS;     // page count
	localparam int SW = ((NW > EW) ? NW : EW) + 1; // page sums
	localparam int CW = $clog2(MAX_REGIONS + 2);  // entry counts
	localparam int IW = $clog2(MAX_REGIONS);      // entry index

	localparam logic [4:0] ATTR_RSV = 5'b10000;

	typedef enum logic [1:0] {
		OP_MAP     = 2'd0,
		OP_RESERVE = 2'd1,
		OP_UNMAP   = 2'd2,
		OP_FAULT   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_INVAL     = 3'd1,
		ST_NOSPACE   = 3'd2,
		ST_FULL      = 3'd3,
		ST_UNHANDLED = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		WR_NONE = 2'd0,
		WR_P1   = 2'd1,
		WR_P2   = 2'd2,
		WR_INS  = 2'd3
	} wr_sel_t;

	typedef struct packed {
		logic [PW-1:0] start_pg;
		logic [EW-1:0] end_pg;
		logic [4:0]    attr;
		logic [PW-1:0] obj_pg;
	} entry_t;

	typedef struct packed {
		logic    load;
		logic    rd;
		logic    adv;
		logic    hole_take;
		logic    cur_upd;
		wr_sel_t wr_sel;
		logic    commit;
		logic    fault_fin;
		logic    set_st;
		status_t st_code;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic arg_ok;
		logic fixed;
		logic empty;
		logic last;
		logic h_skip;
		logic h_fit;
		logic h_end_fit;
		logic p1_v;
		logic p1_ge;
		logic p2_v;
		logic p2_ge;
		logic pend;
		logic f_hit;
	} sts_t;

endpackage

>>> src/address_region_map_allocator_top.sv
// top level of the address region map allocator
// An operation is taken when start is high while busy is low; its single result appears
// on status and the result ports for one cycle with done high, and cannot be held off.
// The block walks the sorted region table one entry per memory read. A fault check reads
// regions until one holds the faulting page, an unmap or reserve visits every stored
// region and a reserve also writes the inserted region, and a map without a fixed address
// first runs a hole search over the regions visited, with a final check when the hole
// lies above the last region.
// The table is kept in two banks of a single-port-write memory; a new table is built in
// the spare bank and swapped in only on success, so a failed operation changes nothing.
// Configuration writes are always taken and must only be issued while the block is idle.
module address_region_map_allocator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [47:0] address,
	input  logic [48:0] length,
	input  logic [4:0]  map_flags,
	input  logic [47:0] object_offset,
	input  logic [1:0]  access_kind,
	output logic        done,
	output logic [2:0]  status,
	output logic [47:0] result_address,
	output logic [47:0] fault_offset,
	output logic [3:0]  fault_region_flags,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [48:0] cfg_data
);

	arma_pkg::cmd_t cmd;
	arma_pkg::sts_t sts;
	logic           start_ok;

	assign cfg_ready = 1'b1;
	assign start_ok  = start && !busy;

	arma_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_ok),
		.busy   (busy),
		.done   (done),
		.sts    (sts),
		.cmd    (cmd)
	);

	arma_datapath u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.op                 (op),
		.address            (address),
		.length             (length),
		.map_flags          (map_flags),
		.object_offset      (object_offset),
		.access_kind        (access_kind),
		.cfg_we             (cfg_valid && cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.status             (status),
		.result_address     (result_address),
		.fault_offset       (fault_offset),
		.fault_region_flags (fault_region_flags)
	);

endmodule

>>> src/arma_datapath.sv
// region table banks, scratch build, hole search and fault lookup datapath
module arma_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  arma_pkg::cmd_t                      cmd,
	output arma_pkg::sts_t                      sts,
	input  logic [1:0]                          op,
	input  logic [47:0]                         address,
	input  logic [48:0]                         length,
	input  logic [4:0]                          map_flags,
	input  logic [47:0]                         object_offset,
	input  logic [1:0]                          access_kind,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [48:0]                         cfg_data,
	output logic [2:0]                          status,
	output logic [47:0]                         result_address,
	output logic [47:0]                         fault_offset,
	output logic [3:0]                          fault_region_flags
);

	localparam int PW = arma_pkg::PW;
	localparam int EW = arma_pkg::EW;
	localparam int NW = arma_pkg::NW;
	localparam int SW = arma_pkg::SW;
	localparam int CW = arma_pkg::CW;
	localparam int IW = arma_pkg::IW;
	localparam int PB = arma_pkg::PAGE_BITS;
	localparam int AB = arma_pkg::ADDR_BITS;
	localparam int MAXR = arma_pkg::MAX_REGIONS;

	// two banks: the committed table and the scratch being built
	arma_pkg::entry_t mem [2*MAXR];

	logic [1:0]      op_q;
	logic [AB-1:0]   addr_q;
	logic [48:0]     len_q;
	logic [4:0]      flags_q;
	logic [AB-1:0]   off_q;
	logic [1:0]      acc_q;
	logic [47:0]     base_q;
	logic [48:0]     size_q;
	logic            bank_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   ridx_q;
	logic [CW-1:0]   wn_q;
	logic            pend_q;
	logic [EW-1:0]   cur_q;
	logic [PW-1:0]   ins_s_q;
	arma_pkg::entry_t rd_q;
	logic [2:0]      status_q;
	logic [47:0]     raddr_q;
	logic [47:0]     foff_q;
	logic [3:0]      fflags_q;

	logic [PW-1:0]   sp;
	logic [NW-1:0]   np;
	logic [PW-1:0]   base_pg;
	logic [SW-1:0]   lim_sum;
	logic [EW-1:0]   lim_pg;
	logic [SW-1:0]   sp_end;
	logic            fits;
	logic            len_ok;
	logic            addr_al;
	logic            off_al;
	logic            hole_map;
	logic [EW-1:0]   cut_s;
	logic [EW-1:0]   cut_e;
	logic [4:0]      ins_attr;
	logic [PW-1:0]   ins_obj;
	logic [SW-1:0]   cur_end;
	logic            keep;
	arma_pkg::entry_t p1;
	arma_pkg::entry_t p2;
	arma_pkg::entry_t ins;
	arma_pkg::entry_t wdata;
	logic            wr;
	logic [IW:0]     waddr;
	logic [IW:0]     raddr;
	logic [PW-1:0]   fault_pg;
	logic            f_ok;

	always_comb begin
		sp      = addr_q[AB-1:PB];
		np      = len_q[48:PB];
		base_pg = base_q[AB-1:PB];
		lim_sum = SW'(base_pg) + SW'(size_q[48:PB]);
		lim_pg  = (lim_sum > (SW'(1) << PW)) ? (EW'(1) << PW) : lim_sum[EW-1:0];
		sp_end  = SW'(sp) + SW'(np);
		fits    = (sp >= base_pg) && (sp_end <= SW'(lim_pg));
		len_ok  = (len_q != '0) && (len_q[PB-1:0] == '0);
		addr_al = (addr_q[PB-1:0] == '0);
		off_al  = (off_q[PB-1:0] == '0);
		hole_map = (op_q == arma_pkg::OP_MAP) && !flags_q[4];
		cut_s   = hole_map ? '0 : EW'(sp);
		cut_e   = hole_map ? '0 : sp_end[EW-1:0];
		ins_attr = (op_q == arma_pkg::OP_RESERVE) ? arma_pkg::ATTR_RSV : {1'b0, flags_q[3:0]};
		ins_obj  = (op_q == arma_pkg::OP_RESERVE) ? '0 : off_q[AB-1:PB];
		cur_end = SW'(cur_q) + SW'(np);

		// pieces of the current entry after cutting [cut_s, cut_e)
		keep = (rd_q.end_pg <= cut_s) || (EW'(rd_q.start_pg) >= cut_e);
		p1 = rd_q;
		if (!keep)
			p1.end_pg = cut_s;
		p2.start_pg = cut_e[PW-1:0];
		p2.end_pg   = rd_q.end_pg;
		p2.attr     = rd_q.attr;
		p2.obj_pg   = rd_q.attr[4] ? '0
			: rd_q.obj_pg + (cut_e[PW-1:0] - rd_q.start_pg);

		ins.start_pg = ins_s_q;
		ins.end_pg   = EW'(SW'(ins_s_q) + SW'(np));
		ins.attr     = ins_attr;
		ins.obj_pg   = ins_obj;

		unique case (cmd.wr_sel)
			arma_pkg::WR_P1:  wdata = p1;
			arma_pkg::WR_P2:  wdata = p2;
			arma_pkg::WR_INS: wdata = ins;
			default:          wdata = p1;
		endcase
		wr    = (cmd.wr_sel != arma_pkg::WR_NONE) && (wn_q < CW'(MAXR));
		waddr = {~bank_q, wn_q[IW-1:0]};
		raddr = {bank_q, ridx_q[IW-1:0]};

		fault_pg = addr_q[AB-1:PB];
		f_ok = !rd_q.attr[4] && (acc_q != 2'd3) && rd_q.attr[acc_q];

		unique case (op_q)
			arma_pkg::OP_MAP:   sts.arg_ok = len_ok && off_al && (!flags_q[4] || (addr_al && fits));
			arma_pkg::OP_FAULT: sts.arg_ok = 1'b1;
			default:            sts.arg_ok = len_ok && addr_al && fits;
		endcase
		sts.op        = arma_pkg::op_t'(op_q);
		sts.fixed     = flags_q[4];
		sts.empty     = (count_q == '0);
		sts.last      = (ridx_q + CW'(1) == count_q);
		sts.h_skip    = (rd_q.end_pg <= cur_q);
		sts.h_fit     = (cur_end <= SW'(rd_q.start_pg)) && (cur_end <= SW'(lim_pg));
		sts.h_end_fit = (cur_end <= SW'(lim_pg));
		sts.p1_v      = keep || (rd_q.start_pg < cut_s[PW-1:0] && EW'(rd_q.start_pg) < cut_s);
		sts.p1_ge     = (rd_q.start_pg >= ins_s_q);
		sts.p2_v      = !keep && (rd_q.end_pg > cut_e);
		sts.p2_ge     = (cut_e >= EW'(ins_s_q));
		sts.pend      = pend_q;
		sts.f_hit     = (fault_pg >= rd_q.start_pg) && (EW'(fault_pg) < rd_q.end_pg);
	end

	always_ff @(posedge clk) begin
		if (wr)
			mem[waddr] <= wdata;
		if (cmd.rd)
			rd_q <= mem[raddr];
		if (cmd.load) begin
			op_q    <= op;
			addr_q  <= address[AB-1:0];
			len_q   <= length;
			flags_q <= map_flags;
			off_q   <= object_offset[AB-1:0];
			acc_q   <= access_kind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			size_q  <= 49'h0_8000_0000_0000;
			bank_q  <= 1'b0;
			count_q <= '0;
			ridx_q  <= '0;
			wn_q    <= '0;
			pend_q  <= 1'b0;
			cur_q   <= '0;
			ins_s_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index)
					size_q <= cfg_data;
				else
					base_q <= cfg_data[47:0];
			end
			if (cmd.load) begin
				ridx_q  <= '0;
				wn_q    <= '0;
				ins_s_q <= address[AB-1:PB];
				pend_q  <= (op == arma_pkg::OP_MAP) || (op == arma_pkg::OP_RESERVE);
				cur_q   <= EW'(base_q[AB-1:PB]);
			end
			if (cmd.adv)
				ridx_q <= ridx_q + CW'(1);
			if (cmd.cur_upd)
				cur_q <= rd_q.end_pg;
			if (cmd.hole_take) begin
				ins_s_q <= cur_q[PW-1:0];
				ridx_q  <= '0;
			end
			if (cmd.wr_sel != arma_pkg::WR_NONE) begin
				wn_q <= wn_q + CW'(1);
				if (cmd.wr_sel == arma_pkg::WR_INS)
					pend_q <= 1'b0;
			end
			if (cmd.commit && wn_q <= CW'(MAXR)) begin
				bank_q  <= ~bank_q;
				count_q <= wn_q;
			end
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.set_st) begin
			status_q <= cmd.st_code;
			raddr_q  <= '0;
			foff_q   <= '0;
			fflags_q <= '0;
		end
		if (cmd.commit) begin
			foff_q   <= '0;
			fflags_q <= '0;
			if (wn_q > CW'(MAXR)) begin
				status_q <= arma_pkg::ST_FULL;
				raddr_q  <= '0;
			end else begin
				status_q <= arma_pkg::ST_OK;
				raddr_q  <= hole_map ? 48'({ins_s_q, {PB{1'b0}}}) : '0;
			end
		end
		if (cmd.fault_fin) begin
			raddr_q <= '0;
			if (f_ok) begin
				status_q <= arma_pkg::ST_OK;
				foff_q   <= 48'({fault_pg - rd_q.start_pg + rd_q.obj_pg, {PB{1'b0}}});
				fflags_q <= rd_q.attr[3:0];
			end else begin
				status_q <= arma_pkg::ST_UNHANDLED;
				foff_q   <= '0;
				fflags_q <= '0;
			end
		end
	end

	assign status             = status_q;
	assign result_address     = raddr_q;
	assign fault_offset       = foff_q;
	assign fault_region_flags = fflags_q;

endmodule

>>> src/arma_ctrl.sv
// operation sequencer for the address region map allocator
module arma_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output logic           done,
	input  arma_pkg::sts_t sts,
	output arma_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_H_RD, S_H_EV, S_H_END, S_C_RD, S_C_P1, S_C_P2,
		S_TAIL, S_COMMIT, S_F_RD, S_F_EV
	} state_t;

	state_t state_q, state_d;
	logic   done_q, done_d;

	always_comb begin
		cmd = '0;
		cmd.wr_sel = arma_pkg::WR_NONE;
		cmd.st_code = arma_pkg::ST_OK;
		state_d = state_q;
		done_d = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (!sts.arg_ok) begin
					cmd.set_st = 1'b1;
					cmd.st_code = arma_pkg::ST_INVAL;
					done_d = 1'b1;
					state_d = S_IDLE;
				end else if (sts.op == arma_pkg::OP_FAULT) begin
					if (sts.empty) begin
						cmd.set_st = 1'b1;
						cmd.st_code = arma_pkg::ST_UNHANDLED;
						done_d = 1'b1;
						state_d = S_IDLE;
					end else begin
						state_d = S_F_RD;
					end
				end else if (sts.op == arma_pkg::OP_MAP && !sts.fixed) begin
					state_d = sts.empty ? S_H_END : S_H_RD;
				end else begin
					state_d = sts.empty ? S_TAIL : S_C_RD;
				end
			end
			S_H_RD: begin
				cmd.rd = 1'b1;
				state_d = S_H_EV;
			end
			S_H_EV: begin
				if (!sts.h_skip && sts.h_fit) begin
					cmd.hole_take = 1'b1;
					state_d = S_C_RD;
				end else begin
					cmd.cur_upd = !sts.h_skip;
					if (sts.last) begin
						state_d = S_H_END;
					end else begin
						cmd.adv = 1'b1;
						state_d = S_H_RD;
					end
				end
			end
			S_H_END: begin
				if (sts.h_end_fit) begin
					cmd.hole_take = 1'b1;
					state_d = sts.empty ? S_TAIL : S_C_RD;
				end else begin
					cmd.set_st = 1'b1;
					cmd.st_code = arma_pkg::ST_NOSPACE;
					done_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_C_RD: begin
				cmd.rd = 1'b1;
				state_d = S_C_P1;
			end
			S_C_P1: begin
				// the new region goes ahead of the first piece not below it
				if (!sts.p1_v) begin
					state_d = S_C_P2;
				end else if (sts.pend && sts.p1_ge) begin
					cmd.wr_sel = arma_pkg::WR_INS;
				end else begin
					cmd.wr_sel = arma_pkg::WR_P1;
					state_d = S_C_P2;
				end
			end
			S_C_P2: begin
				if (sts.p2_v && sts.pend && sts.p2_ge) begin
					cmd.wr_sel = arma_pkg::WR_INS;
				end else begin
					if (sts.p2_v)
						cmd.wr_sel = arma_pkg::WR_P2;
					if (sts.last) begin
						state_d = S_TAIL;
					end else begin
						cmd.adv = 1'b1;
						state_d = S_C_RD;
					end
				end
			end
			S_TAIL: begin
				if (sts.pend)
					cmd.wr_sel = arma_pkg::WR_INS;
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				done_d = 1'b1;
				state_d = S_IDLE;
			end
			S_F_RD: begin
				cmd.rd = 1'b1;
				state_d = S_F_EV;
			end
			S_F_EV: begin
				if (sts.f_hit) begin
					cmd.fault_fin = 1'b1;
					done_d = 1'b1;
					state_d = S_IDLE;
				end else if (sts.last) begin
					cmd.set_st = 1'b1;
					cmd.st_code = arma_pkg::ST_UNHANDLED;
					done_d = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.adv = 1'b1;
					state_d = S_F_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule
